// ===== src/fft8_pkg.sv =====
package fft8_pkg;

  localparam int POINTS           = 8;
  localparam int IDX_W            = $clog2(POINTS);
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int BIN_W            = 20;
  localparam int STAGE_MAX_W      = 36;   // widest stage value: 32-bit samples plus growth
  localparam int HALF_SQRT2_Q15   = 23170;
  localparam int ROUND_Q15        = 16384;

  localparam logic signed [STAGE_MAX_W-1:0] BIN_HI = STAGE_MAX_W'((1 <<< (BIN_W - 1)) - 1);
  localparam logic signed [STAGE_MAX_W-1:0] BIN_LO = -STAGE_MAX_W'(1 <<< (BIN_W - 1));

  // one flag per datapath operation, plus the address it works on
  typedef struct packed {
    logic             load;
    logic             stage1;
    logic             stage2;
    logic             mul;
    logic             stage3;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } fft8_cmd_t;

  function automatic logic [IDX_W-1:0] bitrev(input logic [IDX_W-1:0] n);
    return {n[0], n[1], n[2]};
  endfunction

  function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [STAGE_MAX_W-1:0] v);
    logic signed [STAGE_MAX_W-1:0] c;
    c = v;
    if (v > BIN_HI) begin
      c = BIN_HI;
    end else if (v < BIN_LO) begin
      c = BIN_LO;
    end
    return c[BIN_W-1:0];
  endfunction

endpackage

// ===== src/fft8_ctrl.sv =====
module fft8_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output fft8_pkg::fft8_cmd_t cmd
);
  import fft8_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_ST1  = 3'd1;
  localparam logic [2:0] S_ST2  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ST3  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] emit_r, emit_nxt;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.idx  = bitrev(fill_r);
          fill_nxt = fill_r + 1'b1;
          if (fill_r == LAST_IDX) begin
            state_nxt = S_ST1;
          end
        end
      end
      S_ST1: begin
        cmd.stage1 = 1'b1;
        state_nxt  = S_ST2;
      end
      S_ST2: begin
        cmd.stage2 = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ST3;
      end
      S_ST3: begin
        cmd.stage3 = 1'b1;
        emit_nxt   = '0;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        cmd.idx  = emit_r;
        emit_nxt = emit_r + 1'b1;
        if (emit_r == LAST_IDX) begin
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      fill_r  <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      emit_r  <= emit_nxt;
    end
  end

  assign busy = (state_r != S_LOAD);

  a_frame_starts_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) && start && (fill_r == LAST_IDX) |=> (state_r == S_ST1) && (fill_r == '0))
    else $error("eighth sample did not start the butterfly sequence");

  a_emit_ends_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && (emit_r == LAST_IDX) |=> (state_r == S_LOAD) && (fill_r == '0))
    else $error("frame did not return to loading after the last bin");

endmodule

// ===== src/fft8_dp.sv =====
module fft8_dp #(
  parameter int SAMPLE_WIDTH = fft8_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  fft8_pkg::fft8_cmd_t                      cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]           sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]           sample_imag,
  output logic                                     bin_valid,
  output logic signed [fft8_pkg::BIN_W-1:0]        bin_real,
  output logic signed [fft8_pkg::BIN_W-1:0]        bin_imag,
  output logic [fft8_pkg::IDX_W-1:0]               bin_index,
  output logic                                     bin_last
);
  import fft8_pkg::*;

  // three stages grow a component by less than 12x
  localparam int W  = SAMPLE_WIDTH + 4;
  localparam int PW = W + 16;
  localparam logic signed [15:0]  HS2 = 16'(HALF_SQRT2_Q15);
  localparam logic signed [PW-1:0] RND = PW'(ROUND_Q15);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

  logic signed [W-1:0] re_r [POINTS];
  logic signed [W-1:0] im_r [POINTS];
  logic signed [W-1:0] re_nxt [POINTS];
  logic signed [W-1:0] im_nxt [POINTS];

  // rounded products for the two odd twiddles of stage 3
  logic signed [PW-1:0] p5r_r, p5i_r, p7r_r, p7i_r;
  logic signed [W-1:0]  q5r, q5i, q7r, q7i;
  logic signed [W-1:0]  t5r, t5i, t6r, t6i, t7r, t7i;

  logic                     valid_r;
  logic signed [BIN_W-1:0]  bre_r, bim_r;
  logic [IDX_W-1:0]         bidx_r;
  logic                     blast_r;

  assign q5r = p5r_r[W+14:15];
  assign q5i = p5i_r[W+14:15];
  assign q7r = p7r_r[W+14:15];
  assign q7i = p7i_r[W+14:15];

  assign t5r = q5r + q5i;
  assign t5i = q5i - q5r;
  assign t6r = im_r[6];
  assign t6i = -re_r[6];
  assign t7r = q7i - q7r;
  assign t7i = -q7r - q7i;

  always_comb begin
    re_nxt = re_r;
    im_nxt = im_r;
    if (cmd.load) begin
      re_nxt[cmd.idx] = W'(sample_real);
      im_nxt[cmd.idx] = W'(sample_imag);
    end
    if (cmd.stage1) begin
      for (int i = 0; i < POINTS; i += 2) begin
        re_nxt[i]   = re_r[i] + re_r[i+1];
        im_nxt[i]   = im_r[i] + im_r[i+1];
        re_nxt[i+1] = re_r[i] - re_r[i+1];
        im_nxt[i+1] = im_r[i] - im_r[i+1];
      end
    end
    if (cmd.stage2) begin
      for (int i = 0; i < POINTS; i += 4) begin
        re_nxt[i]   = re_r[i] + re_r[i+2];
        im_nxt[i]   = im_r[i] + im_r[i+2];
        re_nxt[i+2] = re_r[i] - re_r[i+2];
        im_nxt[i+2] = im_r[i] - im_r[i+2];
        // -j twiddle: (re, im) -> (im, -re)
        re_nxt[i+1] = re_r[i+1] + im_r[i+3];
        im_nxt[i+1] = im_r[i+1] - re_r[i+3];
        re_nxt[i+3] = re_r[i+1] - im_r[i+3];
        im_nxt[i+3] = im_r[i+1] + re_r[i+3];
      end
    end
    if (cmd.stage3) begin
      re_nxt[0] = re_r[0] + re_r[4];
      im_nxt[0] = im_r[0] + im_r[4];
      re_nxt[4] = re_r[0] - re_r[4];
      im_nxt[4] = im_r[0] - im_r[4];
      re_nxt[1] = re_r[1] + t5r;
      im_nxt[1] = im_r[1] + t5i;
      re_nxt[5] = re_r[1] - t5r;
      im_nxt[5] = im_r[1] - t5i;
      re_nxt[2] = re_r[2] + t6r;
      im_nxt[2] = im_r[2] + t6i;
      re_nxt[6] = re_r[2] - t6r;
      im_nxt[6] = im_r[2] - t6i;
      re_nxt[3] = re_r[3] + t7r;
      im_nxt[3] = im_r[3] + t7i;
      re_nxt[7] = re_r[3] - t7r;
      im_nxt[7] = im_r[3] - t7i;
    end
    if (cmd.emit) begin
      // advance the bins toward the output tap
      for (int i = 0; i < POINTS - 1; i++) begin
        re_nxt[i] = re_r[i+1];
        im_nxt[i] = im_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < POINTS; i++) begin
      re_r[i] <= re_nxt[i];
      im_r[i] <= im_nxt[i];
    end
    if (cmd.mul) begin
      p5r_r <= PW'(re_r[5]) * PW'(HS2) + RND;
      p5i_r <= PW'(im_r[5]) * PW'(HS2) + RND;
      p7r_r <= PW'(re_r[7]) * PW'(HS2) + RND;
      p7i_r <= PW'(im_r[7]) * PW'(HS2) + RND;
    end
    if (cmd.emit) begin
      bre_r   <= sat_bin(STAGE_MAX_W'(re_r[0]));
      bim_r   <= sat_bin(STAGE_MAX_W'(im_r[0]));
      bidx_r  <= cmd.idx;
      blast_r <= (cmd.idx == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  assign bin_valid = valid_r;
  assign bin_real  = bre_r;
  assign bin_imag  = bim_r;
  assign bin_index = bidx_r;
  assign bin_last  = blast_r;

endmodule

// ===== src/fft_8point_radix2.sv =====
// Eight-point radix-2 decimation-in-time FFT. Drive a complex sample on
// in_sample_real/in_sample_imag with start high; the item is taken at any
// rising edge where start is high and busy is low, so a frame of eight samples
// loads while start is held. The edge that takes the eighth
// sample raises busy; four steps then run the butterfly sequence
// (stage 1, stage 2, the sqrt2/2 products, stage 3) on the eight-entry frame
// store, then the eight bins shift out through one output register.
// Bin 0 reaches the out_ ports through that register once stage 3 is done, and
// bins 1..7 follow on consecutive cycles, each marked by out_valid for exactly
// one cycle; out_last_bin flags bin 7. There is no back-pressure: the receiver
// must take each bin in the cycle it is shown. Frame throughput is limited
// by the single-port emit and the four-step butterfly sequencer; no new
// sample is taken while busy is high. Bins are not scaled; with samples wider
// than 16 bits each component saturates to the 20-bit signed range.
module fft_8point_radix2 #(
  parameter int SAMPLE_WIDTH = fft8_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_imag,
  output logic                              out_valid,
  output logic signed [fft8_pkg::BIN_W-1:0] out_bin_real,
  output logic signed [fft8_pkg::BIN_W-1:0] out_bin_imag,
  output logic [fft8_pkg::IDX_W-1:0]        out_bin_index,
  output logic                              out_last_bin
);
  import fft8_pkg::*;

  fft8_cmd_t cmd;

  // sequence the frame: load, butterflies, emit
  fft8_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // hold the frame store, the butterfly lanes and the output register
  fft8_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sample_real (in_sample_real),
    .sample_imag (in_sample_imag),
    .bin_valid   (out_valid),
    .bin_real    (out_bin_real),
    .bin_imag    (out_bin_imag),
    .bin_index   (out_bin_index),
    .bin_last    (out_last_bin)
  );

  // the last bin leaves as the block is ready for the next frame
  a_last_bin_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_bin |-> !busy)
    else $error("last bin shown while the block is still busy");

  // bins of a frame come back to back in natural order
  a_bins_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_bin |=>
      out_valid && (out_bin_index == $past(out_bin_index) + 3'd1))
    else $error("bin sequence broken");

  // a burst of bins opens with bin 0 while the block is busy
  a_burst_opens_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_bin_index == '0) && busy)
    else $error("bin burst did not start at bin 0");

endmodule
